[design/ipv4hc_pkg.sv]
// Package for the IPv4 header checker: beat types, header summary record,
// verdict codes and shared constants. No dependencies.
package ipv4hc_pkg;

	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [5:0]  POS_MAX      = 6'd63;
	localparam logic [5:0]  MIN_HEADER   = 6'd20;
	localparam logic [5:0]  POS_CSUM_HI  = 6'd10;
	localparam logic [5:0]  POS_CSUM_LO  = 6'd11;
	localparam logic [5:0]  POS_PROTO    = 6'd9;
	localparam logic [5:0]  POS_VL       = 6'd0;
	localparam logic [5:0]  POS_SRC_FIRST = 6'd12;
	localparam logic [5:0]  POS_SRC_LAST  = 6'd15;
	localparam logic [5:0]  POS_DST_FIRST = 6'd16;
	localparam logic [5:0]  POS_DST_LAST  = 6'd19;
	localparam logic [3:0]  IP_VERSION   = 4'd4;
	localparam logic [7:0]  PROTO_ICMP   = 8'd1;
	localparam logic [7:0]  PROTO_TCP    = 8'd6;
	localparam logic [7:0]  PROTO_UDP    = 8'd17;
	localparam logic [31:0] ALL_ONES_ADDR = 32'hFFFF_FFFF;
	localparam logic [31:0] MASK_RESET   = 32'hFFFF_FF00;

	localparam logic REG_LOCAL_ADDR  = 1'b0;
	localparam logic REG_SUBNET_MASK = 1'b1;

	typedef enum logic [2:0] {
		ST_DELIVER     = 3'd0,
		ST_TOO_SHORT   = 3'd1,
		ST_BAD_VERSION = 3'd2,
		ST_BAD_HDR_LEN = 3'd3,
		ST_BAD_CSUM    = 3'd4,
		ST_NOT_FOR_US  = 3'd5,
		ST_UNKNOWN_PROTO = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		TR_NONE = 2'd0,
		TR_ICMP = 2'd1,
		TR_TCP  = 2'd2,
		TR_UDP  = 2'd3
	} transport_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_beat_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [1:0]  transport;
		logic [31:0] source_address;
		logic [5:0]  header_bytes;
	} out_beat_t;

	// header summary handed from parser to judge, one per packet
	typedef struct packed {
		logic [5:0]  len;
		logic [7:0]  ver_ihl;
		logic [7:0]  proto;
		logic [15:0] csum;
		logic [15:0] sum;
		logic [31:0] src;
		logic [31:0] dst;
	} hdr_sum_t;

endpackage

[design/ipv4_header_checker.sv]
// IPv4 header checker top level: register port, parser, summary queue, judge.
// Uses ipv4hc_pkg, ipv4hc_parse, ipv4hc_queue, ipv4hc_judge.
// Throughput: one byte per cycle while in_stall is low; up to one verdict per cycle.
// The last byte's summary is written into the summary queue; the judge registers its verdict on pop.
// Input stalls whenever both summary queue entries are occupied, which follows a stalled output.
// Reset clears packet state and queue; local_address 0, subnet_mask 255.255.255.0.
module ipv4_header_checker (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  ipv4hc_pkg::in_beat_t  in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output ipv4hc_pkg::out_beat_t out_data,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);
	import ipv4hc_pkg::*;

	logic [31:0] local_addr_q;
	logic [31:0] subnet_mask_q;
	logic        beat_take;
	logic        push;
	logic        full;
	logic        pop;
	logic        head_valid;
	hdr_sum_t    push_data;
	hdr_sum_t    head_data;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_SUBNET_MASK) ? subnet_mask_q : local_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_addr_q  <= '0;
			subnet_mask_q <= MASK_RESET;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_SUBNET_MASK) begin
				subnet_mask_q <= pwdata;
			end else begin
				local_addr_q <= pwdata;
			end
		end
	end

	assign in_stall  = full;
	assign beat_take = in_valid && !in_stall;

	ipv4hc_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.beat_take (beat_take),
		.beat      (in_data),
		.push      (push),
		.push_data (push_data)
	);

	ipv4hc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	ipv4hc_judge u_judge (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_data   (head_data),
		.pop         (pop),
		.local_addr  (local_addr_q),
		.subnet_mask (subnet_mask_q),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

endmodule

[design/ipv4hc_parse.sv]
// Front part: takes packet bytes, captures header fields and the running
// ones'-complement sum, and pushes one header summary per packet. Uses ipv4hc_pkg.
module ipv4hc_parse (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 beat_take,
	input  ipv4hc_pkg::in_beat_t beat,
	output logic                 push,
	output ipv4hc_pkg::hdr_sum_t push_data
);
	import ipv4hc_pkg::*;

	logic [5:0]  pos_q;
	logic [7:0]  vl_q;
	logic [7:0]  proto_q;
	logic [15:0] csum_q;
	logic [31:0] src_q;
	logic [31:0] dst_q;
	logic [15:0] sum_q;
	logic [7:0]  hold_q;

	logic [5:0]  pos_n;
	logic [7:0]  vl_n;
	logic [7:0]  proto_n;
	logic [15:0] csum_n;
	logic [31:0] src_n;
	logic [31:0] dst_n;
	logic [15:0] sum_n;
	logic [7:0]  hold_n;
	logic [7:0]  sum_byte;
	logic [5:0]  hdr_len;
	logic [16:0] wide_sum;
	logic        is_csum;

	always_comb begin
		pos_n    = pos_q;
		vl_n     = vl_q;
		proto_n  = proto_q;
		csum_n   = csum_q;
		src_n    = src_q;
		dst_n    = dst_q;
		sum_n    = sum_q;
		hold_n   = hold_q;
		is_csum  = (pos_q == POS_CSUM_HI) || (pos_q == POS_CSUM_LO);
		sum_byte = is_csum ? 8'd0 : beat.data_byte;
		if (pos_q == POS_VL) begin
			vl_n = beat.data_byte;
		end
		if (pos_q == POS_PROTO) begin
			proto_n = beat.data_byte;
		end
		if (is_csum) begin
			csum_n = {csum_q[7:0], beat.data_byte};
		end
		if (pos_q >= POS_SRC_FIRST && pos_q <= POS_SRC_LAST) begin
			src_n = {src_q[23:0], beat.data_byte};
		end
		if (pos_q >= POS_DST_FIRST && pos_q <= POS_DST_LAST) begin
			dst_n = {dst_q[23:0], beat.data_byte};
		end
		hdr_len  = {vl_n[3:0], 2'b00};
		wide_sum = {1'b0, sum_q} + {1'b0, hold_q, sum_byte};
		if (pos_q < hdr_len) begin
			if (!pos_q[0]) begin
				hold_n = sum_byte;
			end else begin
				sum_n = wide_sum[15:0] + {15'd0, wide_sum[16]};
			end
		end
		if (pos_q != POS_MAX) begin
			pos_n = pos_q + 6'd1;
		end else begin
			vl_n    = vl_q;
			proto_n = proto_q;
			csum_n  = csum_q;
			src_n   = src_q;
			dst_n   = dst_q;
			sum_n   = sum_q;
			hold_n  = hold_q;
		end
	end

	assign push = beat_take && beat.last_byte;
	assign push_data = '{len: pos_n, ver_ihl: vl_n, proto: proto_n, csum: csum_n,
		sum: sum_n, src: src_n, dst: dst_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			vl_q    <= '0;
			proto_q <= '0;
			csum_q  <= '0;
			src_q   <= '0;
			dst_q   <= '0;
			sum_q   <= '0;
			hold_q  <= '0;
		end else if (beat_take) begin
			if (beat.last_byte) begin
				pos_q   <= '0;
				vl_q    <= '0;
				proto_q <= '0;
				csum_q  <= '0;
				src_q   <= '0;
				dst_q   <= '0;
				sum_q   <= '0;
				hold_q  <= '0;
			end else begin
				pos_q   <= pos_n;
				vl_q    <= vl_n;
				proto_q <= proto_n;
				csum_q  <= csum_n;
				src_q   <= src_n;
				dst_q   <= dst_n;
				sum_q   <= sum_n;
				hold_q  <= hold_n;
			end
		end
	end

endmodule

[design/ipv4hc_queue.sv]
// Short queue of header summaries between parser and judge.
// Uses ipv4hc_pkg.
module ipv4hc_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  ipv4hc_pkg::hdr_sum_t push_data,
	output logic                 full,
	input  logic                 pop,
	output logic                 head_valid,
	output ipv4hc_pkg::hdr_sum_t head_data
);
	import ipv4hc_pkg::*;

	hdr_sum_t            entry_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		ptr_inc = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	assign full       = (count_q == QCNT_W'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid) else $error("queue pop while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH)) else $error("queue count out of range");
`endif

endmodule

[design/ipv4hc_judge.sv]
// Back part: turns a header summary into a verdict and holds it in the
// output register until taken. Uses ipv4hc_pkg.
module ipv4hc_judge (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  head_valid,
	input  ipv4hc_pkg::hdr_sum_t  head_data,
	output logic                  pop,
	input  logic [31:0]           local_addr,
	input  logic [31:0]           subnet_mask,
	output logic                  out_valid,
	input  logic                  out_stall,
	output ipv4hc_pkg::out_beat_t out_data
);
	import ipv4hc_pkg::*;

	logic      out_valid_q;
	out_beat_t out_data_q;
	out_beat_t verdict;
	logic [5:0]  hdr_len;
	logic [31:0] host;

	always_comb begin
		hdr_len = {head_data.ver_ihl[3:0], 2'b00};
		host    = ~subnet_mask;
		verdict = '{status: ST_DELIVER, transport: TR_NONE, source_address: '0,
			header_bytes: '0};
		if (head_data.len < MIN_HEADER) begin
			verdict.status = ST_TOO_SHORT;
		end else if (head_data.ver_ihl[7:4] != IP_VERSION) begin
			verdict.status = ST_BAD_VERSION;
		end else if (hdr_len < MIN_HEADER || head_data.len < hdr_len) begin
			verdict.status = ST_BAD_HDR_LEN;
		end else if (~head_data.sum != head_data.csum) begin
			verdict.status = ST_BAD_CSUM;
		end else if (head_data.dst != local_addr && head_data.dst != ALL_ONES_ADDR
			&& (head_data.dst & host) != host) begin
			verdict.status = ST_NOT_FOR_US;
		end else begin
			verdict.source_address = head_data.src;
			verdict.header_bytes   = hdr_len;
			case (head_data.proto)
				PROTO_ICMP: verdict.transport = TR_ICMP;
				PROTO_TCP:  verdict.transport = TR_TCP;
				PROTO_UDP:  verdict.transport = TR_UDP;
				default:    verdict.status    = ST_UNKNOWN_PROTO;
			endcase
		end
	end

	assign pop       = head_valid && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			out_data_q <= verdict;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_deliver_has_route: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q.status == ST_DELIVER |-> out_data_q.transport != TR_NONE)
		else $error("deliver verdict without transport");
	a_reject_no_route: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q.status != ST_DELIVER |-> out_data_q.transport == TR_NONE)
		else $error("reject verdict with transport");
	a_reject_no_source: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q.status != ST_DELIVER
		&& out_data_q.status != ST_UNKNOWN_PROTO |-> out_data_q.source_address == '0)
		else $error("header check failure carries a source address");
`endif

endmodule
